/* hdl/square_matrix_times_vectors_defines.svh */
// assertion macros for the square matrix times vectors block
// no dependencies; expects clk and arst_n in the including module
`ifndef SQUARE_MATRIX_TIMES_VECTORS_DEFINES_SVH
`define SQUARE_MATRIX_TIMES_VECTORS_DEFINES_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define SMTV_ASSERT_NOW(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("smtv assertion failed");
// next-cycle implication
`define SMTV_ASSERT_NEXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("smtv assertion failed");
`else
`define SMTV_ASSERT_NOW(label, pre, post)
`define SMTV_ASSERT_NEXT(label, pre, post)
`endif
`endif

/* hdl/smtv_pkg.sv */
// shared types and constants for the square matrix times vectors block
// no dependencies
package smtv_pkg;

	localparam int DEF_MAX_SIZE     = 8;
	localparam int DEF_MAX_VECTORS  = 8;
	localparam int DEF_NUM_MATRICES = 16;

	// field widths
	localparam int VAL_W = 16;
	localparam int CNT_W = 4;
	localparam int IDX_W = 5;

	typedef enum logic [1:0] {
		ACT_LOAD_MAT = 2'd0,
		ACT_LOAD_VEC = 2'd1,
		ACT_COMPUTE  = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		REG_SIZE     = 2'd0,
		REG_VECTORS  = 2'd1,
		REG_SELECTED = 2'd2
	} reg_idx_t;

	// element write broadcast to all cells
	typedef struct packed {
		logic                    a_we;
		logic                    v_we;
		logic [2:0]              row;
		logic [2:0]              col;
		logic signed [VAL_W-1:0] data;
	} ld_t;

	// product element travelling down the chain
	typedef struct packed {
		logic             valid;
		logic             last;
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
	} tok_t;

endpackage

/* hdl/smtv_cell.sv */
// one multiply-accumulate cell: holds matrix column K and vector row K
// depends on smtv_pkg
module smtv_cell import smtv_pkg::*; #(
	parameter int MAX_SIZE    = DEF_MAX_SIZE,
	parameter int MAX_VECTORS = DEF_MAX_VECTORS,
	parameter int K           = 0,
	parameter int ACC_W       = 32 + $clog2(DEF_MAX_SIZE)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  ld_t                     ld,
	input  logic [CNT_W-1:0]        n_eff,
	input  tok_t                    tok_in,
	input  logic signed [ACC_W-1:0] psum_in,
	output tok_t                    tok_out,
	output logic signed [ACC_W-1:0] psum_out
);

	localparam int IW = $clog2(MAX_SIZE);
	localparam int JW = (MAX_VECTORS > 1) ? $clog2(MAX_VECTORS) : 1;

	logic signed [VAL_W-1:0] a_q [MAX_SIZE];
	logic signed [VAL_W-1:0] v_q [MAX_VECTORS];
	tok_t                    tok_q;
	logic signed [ACC_W-1:0] psum_q;
	logic signed [2*VAL_W-1:0] prod;
	logic                    active;

	// local element stores, written by the load broadcast
	always_ff @(posedge clk) begin
		if (ld.a_we && (IDX_W'(ld.col) == IDX_W'(K))) begin
			a_q[IW'(ld.row)] <= ld.data;
		end
		if (ld.v_we && (IDX_W'(ld.row) == IDX_W'(K))) begin
			v_q[JW'(ld.col)] <= ld.data;
		end
	end

	// multiply-accumulate, idle cells beyond the used size pass through
	assign active = ({1'b0, n_eff} > IDX_W'(K));
	assign prod   = a_q[tok_in.row[IW-1:0]] * v_q[tok_in.col[JW-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_in;
		end
	end

	always_ff @(posedge clk) begin
		psum_q <= active ? (psum_in + ACC_W'(prod)) : psum_in;
	end

	assign tok_out  = tok_q;
	assign psum_out = psum_q;

	`include "square_matrix_times_vectors_defines.svh"
	`SMTV_ASSERT_NEXT(a_tok_moves, tok_in.valid, tok_q.valid)

endmodule

/* hdl/square_matrix_times_vectors.sv */
// Square matrix times a block of column vectors, Q4.12 operands, Q8.24 results.
// A load beat (matrix or vector element) is written when accepted; busy stays
// low. A compute beat raises busy and issues n*m product elements, one per cycle,
// into a chain of MAX_SIZE multiply-accumulate cells. Each element passes the
// MAX_SIZE cell registers and the output register before it shows on the result
// ports. busy drops in the cycle that carries the last result. Results come out
// one per cycle in row-major order, each valid only while strobe is high for that
// single cycle; the receiver cannot stall them and must take every one. last
// marks the final element. The user must write configuration over the APB port
// only while busy is low; the block itself does not enforce it.
// depends on smtv_pkg, smtv_cell and square_matrix_times_vectors_defines.svh
module square_matrix_times_vectors import smtv_pkg::*; #(
	parameter int MAX_SIZE     = DEF_MAX_SIZE,
	parameter int MAX_VECTORS  = DEF_MAX_VECTORS,
	parameter int NUM_MATRICES = DEF_NUM_MATRICES
) (
	input  logic                    clk,
	input  logic                    arst_n,
	// apb configuration
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [3:0]              paddr,
	input  logic [31:0]             pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	// command
	input  logic                    start,
	output logic                    busy,
	input  logic [1:0]              action,
	input  logic [3:0]              matrix_index,
	input  logic [2:0]              row,
	input  logic [2:0]              col,
	input  logic signed [VAL_W-1:0] value,
	// results
	output logic                    strobe,
	output logic [2:0]              out_row,
	output logic [2:0]              out_col,
	output logic signed [31:0]      out_value,
	output logic                    last
);

	localparam int ACC_W = 32 + $clog2(MAX_SIZE);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_ISSUE = 3'b010,
		ST_DRAIN = 3'b100
	} state_t;

	logic [CNT_W-1:0] size_q, vectors_q, selected_q;
	logic [CNT_W-1:0] n_eff, m_eff;
	logic [CNT_W-1:0] i_q, j_q;
	state_t           state_q;
	logic             accept, cfg_we, issue_last, start_compute;
	ld_t              ld;
	tok_t             tok [MAX_SIZE+1];
	logic signed [ACC_W-1:0] psum [MAX_SIZE+1];
	logic             strobe_q, last_q;
	logic [2:0]       out_row_q, out_col_q;
	logic signed [31:0] out_value_q;
	logic signed [ACC_W-1:0] acc_end;

	// configuration registers
	assign cfg_we = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q     <= CNT_W'(8);
			vectors_q  <= CNT_W'(8);
			selected_q <= '0;
		end else if (cfg_we) begin
			case (paddr[3:2])
				REG_SIZE:     size_q     <= pwdata[CNT_W-1:0];
				REG_VECTORS:  vectors_q  <= pwdata[CNT_W-1:0];
				REG_SELECTED: selected_q <= pwdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_SIZE:     prdata = 32'(size_q);
			REG_VECTORS:  prdata = 32'(vectors_q);
			REG_SELECTED: prdata = 32'(selected_q);
			default:      prdata = '0;
		endcase
	end

	// counts clamped to the built size
	assign n_eff = (32'(size_q) > MAX_SIZE) ? CNT_W'(MAX_SIZE) : size_q;
	assign m_eff = (32'(vectors_q) > MAX_VECTORS) ? CNT_W'(MAX_VECTORS) : vectors_q;

	// load broadcast
	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign start_compute = accept && (action == ACT_COMPUTE) && (n_eff != '0)
		&& (m_eff != '0);

	always_comb begin
		ld.row  = row;
		ld.col  = col;
		ld.data = value;
		ld.a_we = accept && (action == ACT_LOAD_MAT) && (matrix_index == selected_q)
			&& (32'(matrix_index) < NUM_MATRICES)
			&& (32'(row) < MAX_SIZE) && (32'(col) < MAX_SIZE);
		ld.v_we = accept && (action == ACT_LOAD_VEC)
			&& (32'(row) < MAX_SIZE) && (32'(col) < MAX_VECTORS);
	end

	// issue sequencer
	assign issue_last = (i_q == n_eff - 1'b1) && (j_q == m_eff - 1'b1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			i_q     <= '0;
			j_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					i_q <= '0;
					j_q <= '0;
					if (start_compute) begin
						state_q <= ST_ISSUE;
					end
				end
				ST_ISSUE: begin
					if (issue_last) begin
						state_q <= ST_DRAIN;
					end else if (j_q == m_eff - 1'b1) begin
						j_q <= '0;
						i_q <= i_q + 1'b1;
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					if (tok[MAX_SIZE].valid && tok[MAX_SIZE].last) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// chain of cells
	assign tok[0] = '{
		valid: (state_q == ST_ISSUE),
		last:  issue_last,
		row:   IDX_W'(i_q),
		col:   IDX_W'(j_q)
	};
	assign psum[0] = '0;

	for (genvar k = 0; k < MAX_SIZE; k++) begin : g_cell
		smtv_cell #(
			.MAX_SIZE   (MAX_SIZE),
			.MAX_VECTORS(MAX_VECTORS),
			.K          (k),
			.ACC_W      (ACC_W)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ld      (ld),
			.n_eff   (n_eff),
			.tok_in  (tok[k]),
			.psum_in (psum[k]),
			.tok_out (tok[k+1]),
			.psum_out(psum[k+1])
		);
	end

	// saturation and output register
	assign acc_end = psum[MAX_SIZE];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
			last_q   <= 1'b0;
		end else begin
			strobe_q <= tok[MAX_SIZE].valid;
			last_q   <= tok[MAX_SIZE].valid && tok[MAX_SIZE].last;
		end
	end

	always_ff @(posedge clk) begin
		out_row_q <= tok[MAX_SIZE].row[2:0];
		out_col_q <= tok[MAX_SIZE].col[2:0];
		if ((&acc_end[ACC_W-1:31]) || !(|acc_end[ACC_W-1:31])) begin
			out_value_q <= acc_end[31:0];
		end else if (acc_end[ACC_W-1]) begin
			out_value_q <= 32'sh8000_0000;
		end else begin
			out_value_q <= 32'sh7FFF_FFFF;
		end
	end

	assign strobe    = strobe_q;
	assign last      = last_q;
	assign out_row   = out_row_q;
	assign out_col   = out_col_q;
	assign out_value = out_value_q;

	`include "square_matrix_times_vectors_defines.svh"
	`SMTV_ASSERT_NOW(a_strobe_from_busy, strobe, $past(busy))
	`SMTV_ASSERT_NEXT(a_last_ends_burst, strobe && last, !strobe)
	`SMTV_ASSERT_NEXT(a_compute_busy, start_compute, busy)
	`SMTV_ASSERT_NOW(a_issue_only_busy, tok[0].valid, busy)

endmodule

/* sim/testbench.sv */
// self-checking testbench for square_matrix_times_vectors: loads, computes, apb config
// keeps its own matrix/vector copy and predicts every product beat in order
// depends on smtv_pkg and the square_matrix_times_vectors rtl
module testbench;
	import smtv_pkg::*;

	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam logic [1:0] REG_EXTRA  = 2'd3;
	localparam int         NSZ        = DEF_MAX_SIZE;
	localparam int         NVEC       = DEF_MAX_VECTORS;

	typedef struct {
		logic [2:0]         prow;
		logic [2:0]         pcol;
		logic signed [31:0] pval;
		logic               plast;
	} product_t;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [3:0]         paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;
	logic               start;
	logic               busy;
	logic [1:0]         action;
	logic [3:0]         matrix_index;
	logic [2:0]         row;
	logic [2:0]         col;
	logic signed [15:0] value;
	logic               strobe;
	logic [2:0]         out_row;
	logic [2:0]         out_col;
	logic signed [31:0] out_value;
	logic               last;

	// shadow state of the block
	logic signed [15:0] mat_copy [NSZ*NSZ];
	logic signed [15:0] vec_copy [NSZ*NVEC];
	logic [3:0]         size_reg;
	logic [3:0]         vec_reg;
	logic [3:0]         sel_reg;
	product_t           product_q [$];
	int                 mismatches;

	square_matrix_times_vectors u_top (.*);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog
	initial begin
		#3000000;
		$display("testbench NOT OK");
		$finish;
	end

	// result checker: every strobe beat must match the oldest prediction
	always @(posedge clk) begin
		product_t exp_p;
		if (arst_n && strobe) begin
			if (product_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected beat row %0d col %0d value %0d", out_row, out_col,
						out_value);
			end else begin
				exp_p = product_q.pop_front();
				if (out_row !== exp_p.prow || out_col !== exp_p.pcol ||
				    out_value !== exp_p.pval || last !== exp_p.plast) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch exp r%0d c%0d v%0d l%0d got r%0d c%0d v%0d l%0d",
							exp_p.prow, exp_p.pcol, exp_p.pval, exp_p.plast,
							out_row, out_col, out_value, last);
				end
			end
		end
	end

	// predict the product block for a compute beat
	task automatic predict_products();
		int     n, m;
		longint acc;
		product_t p;
		n = (size_reg > NSZ) ? NSZ : size_reg;
		m = (vec_reg > NVEC) ? NVEC : vec_reg;
		for (int i = 0; i < n; i++) begin
			for (int j = 0; j < m; j++) begin
				acc = 0;
				for (int k = 0; k < n; k++)
					acc += longint'(mat_copy[i*NSZ+k]) * longint'(vec_copy[k*NVEC+j]);
				if (acc > 64'sd2147483647) acc = 64'sd2147483647;
				else if (acc < -64'sd2147483648) acc = -64'sd2147483648;
				p.prow  = i[2:0];
				p.pcol  = j[2:0];
				p.pval  = acc[31:0];
				p.plast = (i == n-1 && j == m-1);
				product_q.push_back(p);
			end
		end
	endtask

	// send one command beat and update the shadow state on acceptance
	task automatic send_item(logic [1:0] act, logic [3:0] midx, logic [2:0] r,
	                         logic [2:0] c, logic signed [15:0] v);
		@(negedge clk);
		start        <= 1'b1;
		action       <= act;
		matrix_index <= midx;
		row          <= r;
		col          <= c;
		value        <= v;
		do @(posedge clk); while (busy);
		case (act)
			ACT_LOAD_MAT: begin
				if (midx == sel_reg) mat_copy[r*NSZ+c] = v;
			end
			ACT_LOAD_VEC: begin
				vec_copy[r*NVEC+c] = v;
			end
			ACT_COMPUTE: begin
				predict_products();
			end
			default: ;
		endcase
	endtask

	task automatic idle_cycles(int k);
		repeat (k) begin
			@(negedge clk);
			start <= 1'b0;
		end
	endtask

	// drain all results, then let the chain empty
	task automatic wait_idle();
		idle_cycles(1);
		while (product_q.size() != 0) @(posedge clk);
		repeat (NSZ + 4) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	// apb write: setup then access
	task automatic write_reg(logic [1:0] idx, logic [31:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		case (idx)
			REG_SIZE:     size_reg = data[3:0];
			REG_VECTORS:  vec_reg  = data[3:0];
			REG_SELECTED: sel_reg  = data[3:0];
			default: ;
		endcase
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic setup_regs(logic [3:0] n, logic [3:0] m, logic [3:0] s);
		write_reg(REG_SIZE, {$urandom} & 32'hFFFF_FFF0 | n);
		write_reg(REG_VECTORS, m);
		write_reg(REG_SELECTED, s);
	endtask

	// every element gets written once so no compute reads an unwritten cell
	task automatic test_preload();
		for (int r = 0; r < NSZ; r++)
			for (int c = 0; c < NSZ; c++) begin
				send_item(ACT_LOAD_MAT, sel_reg, r[2:0], c[2:0], 16'($urandom));
				send_item(ACT_LOAD_VEC, 4'($urandom), r[2:0], c[2:0], 16'($urandom));
			end
		send_item(ACT_COMPUTE, 4'd0, 3'd0, 3'd0, 16'd0);
		wait_idle();
	endtask

	// saturation both ways, unselected loads, unused action
	task automatic test_directed();
		setup_regs(4'd3, 4'd2, 4'd0);
		for (int k = 0; k < 3; k++) begin
			send_item(ACT_LOAD_MAT, 4'd0, 3'd0, k[2:0], -16'sd32768);
			send_item(ACT_LOAD_VEC, 4'd0, k[2:0], 3'd0, -16'sd32768);
			send_item(ACT_LOAD_VEC, 4'd0, k[2:0], 3'd1, 16'sd32767);
		end
		// unselected matrix index is dropped
		send_item(ACT_LOAD_MAT, 4'd15, 3'd0, 3'd0, 16'sd1);
		send_item(ACT_UNUSED, 4'd0, 3'd7, 3'd7, 16'sd100);
		send_item(ACT_COMPUTE, 4'd0, 3'd0, 3'd0, 16'd0);
		send_item(ACT_LOAD_VEC, 4'd0, 3'd7, 3'd7, 16'sd32767);
		send_item(ACT_LOAD_MAT, 4'd0, 3'd7, 3'd7, -16'sd32768);
		wait_idle();
		// oversize saturates to full size, unused register ignored
		setup_regs(4'd15, 4'd15, 4'd9);
		write_reg(REG_EXTRA, 32'h1);
		send_item(ACT_LOAD_MAT, 4'd9, 3'd3, 3'd4, 16'sd4096);
		send_item(ACT_COMPUTE, 4'd0, 3'd0, 3'd0, 16'd0);
		wait_idle();
		// zero size and zero vectors give no beats
		setup_regs(4'd0, 4'd5, 4'd9);
		send_item(ACT_COMPUTE, 4'd0, 3'd0, 3'd0, 16'd0);
		wait_idle();
		setup_regs(4'd4, 4'd0, 4'd9);
		send_item(ACT_COMPUTE, 4'd0, 3'd0, 3'd0, 16'd0);
		wait_idle();
		setup_regs(4'd1, 4'd1, 4'd9);
		send_item(ACT_COMPUTE, 4'd0, 3'd0, 3'd0, 16'd0);
		wait_idle();
	endtask

	function automatic logic [3:0] pick_count();
		int d;
		d = $urandom_range(19);
		if (d == 0) return 4'd0;
		if (d == 1) return 4'd15;
		if (d == 2) return 4'($urandom_range(15, 9));
		return 4'($urandom_range(8, 1));
	endfunction

	function automatic logic signed [15:0] pick_value();
		case ($urandom_range(7))
			0: return -16'sd32768;
			1: return 16'sd32767;
			default: return 16'($urandom);
		endcase
	endfunction

	// random loads and computes with sender gaps
	task automatic test_random(int gap_pct, int items);
		int d;
		logic [3:0] midx;
		setup_regs(pick_count(), pick_count(), 4'($urandom));
		for (int t = 0; t < items; t++) begin
			if ($urandom_range(99) < gap_pct) idle_cycles($urandom_range(4, 1));
			d = $urandom_range(99);
			midx = ($urandom_range(3) == 0) ? 4'($urandom) : sel_reg;
			if (d < 45)
				send_item(ACT_LOAD_MAT, midx, 3'($urandom), 3'($urandom), pick_value());
			else if (d < 82)
				send_item(ACT_LOAD_VEC, 4'($urandom), 3'($urandom), 3'($urandom),
					pick_value());
			else if (d < 86)
				send_item(ACT_UNUSED, 4'($urandom), 3'($urandom), 3'($urandom),
					16'($urandom));
			else
				send_item(ACT_COMPUTE, 4'($urandom), 3'($urandom), 3'($urandom),
					16'($urandom));
			if (d == 99) wait_idle();
		end
		wait_idle();
	endtask

	initial begin
		arst_n       = 1'b0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		start        = 1'b0;
		action       = ACT_LOAD_MAT;
		matrix_index = '0;
		row          = '0;
		col          = '0;
		value        = '0;
		size_reg     = 4'd8;
		vec_reg      = 4'd8;
		sel_reg      = 4'd0;
		mismatches   = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_preload();
		test_directed();
		test_random(0, 6);
		test_random(84, 5);
		test_random(0, 6);
		test_random(10, 5);
		if (mismatches == 0 && product_q.size() == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end
endmodule
